### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// clocked assertion, off while reset is asserted (active low)
`define TCW_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked assertion that also holds across reset
`define TCW_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TCW_ASSERT(lbl, clk, rst_n, prop, msg)
`define TCW_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

### src/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Types and constants shared by the text console writer modules.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int unsigned DEF_COLUMNS = 80;
    localparam int unsigned DEF_ROWS    = 25;

    localparam int unsigned OP_W     = 2;
    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned ATTR_W   = 8;
    localparam int unsigned CELL_W   = CHAR_W + ATTR_W;
    localparam int unsigned TAB_STEP = 4;

    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned APB_DATA_W = 32;

    localparam logic [CHAR_W-1:0] RST_ATTR      = 8'd0;
    localparam logic [CHAR_W-1:0] RST_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] RST_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] RST_TAB       = 8'd9;

    typedef enum logic [OP_W-1:0] {
        OP_PUT   = 2'd0,
        OP_SET   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    typedef struct packed {
        logic [ATTR_W-1:0] text_attribute;
        logic [CHAR_W-1:0] newline_code;
        logic [CHAR_W-1:0] backspace_code;
        logic [CHAR_W-1:0] tab_code;
    } t_cfg;

    typedef struct packed {
        logic load;        // capture the input word
        logic exec;        // decode and update cursor, write or read a cell
        logic sweep_step;  // zero one cell of the sweep range
        logic finish;      // load the result registers and strobe
        logic rd_sel;      // result carries the read cell
    } t_dp_cmd;

    typedef struct packed {
        logic go_clear;
        logic go_scroll;
        logic go_read;
        logic sweep_done;
    } t_dp_status;

endpackage

### src/tcw_regs.sv
// ----------------------------------------------------------------------------
// tcw_regs
// APB register file: attribute byte and the three control character codes.
// ----------------------------------------------------------------------------
module tcw_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tcw_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [tcw_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [tcw_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    output tcw_pkg::t_cfg                    o_cfg
);
    import tcw_pkg::*;

    typedef enum logic [1:0] {
        REG_ATTR      = 2'd0,
        REG_NEWLINE   = 2'd1,
        REG_BACKSPACE = 2'd2,
        REG_TAB       = 2'd3
    } t_reg_idx;

    t_cfg              r_cfg;
    t_reg_idx          w_idx;
    logic              w_wr;
    logic [CHAR_W-1:0] w_rd_val;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.text_attribute <= RST_ATTR;
            r_cfg.newline_code   <= RST_NEWLINE;
            r_cfg.backspace_code <= RST_BACKSPACE;
            r_cfg.tab_code       <= RST_TAB;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_ATTR:      r_cfg.text_attribute <= pwdata[CHAR_W-1:0];
                REG_NEWLINE:   r_cfg.newline_code   <= pwdata[CHAR_W-1:0];
                REG_BACKSPACE: r_cfg.backspace_code <= pwdata[CHAR_W-1:0];
                REG_TAB:       r_cfg.tab_code       <= pwdata[CHAR_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_ATTR:      w_rd_val = r_cfg.text_attribute;
            REG_NEWLINE:   w_rd_val = r_cfg.newline_code;
            REG_BACKSPACE: w_rd_val = r_cfg.backspace_code;
            REG_TAB:       w_rd_val = r_cfg.tab_code;
        endcase
    end

    assign prdata = APB_DATA_W'(w_rd_val);
    assign o_cfg  = r_cfg;

endmodule

### src/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer: reset clearing pass, command accept, execute, read wait, sweeps.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tcw_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  tcw_pkg::t_dp_status   i_status,
    output tcw_pkg::t_dp_cmd      o_cmd
);
    import tcw_pkg::*;

    typedef enum logic [4:0] {
        ST_INIT  = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_EXEC  = 5'b00100,
        ST_READ  = 5'b01000,
        ST_SWEEP = 5'b10000
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_dp_cmd w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        unique case (r_state)
            ST_INIT: begin
                w_cmd.sweep_step = 1'b1;
                if (i_status.sweep_done) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (start) begin
                    w_cmd.load = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                w_cmd.exec = 1'b1;
                priority if (i_status.go_clear || i_status.go_scroll) begin
                    n_state = ST_SWEEP;
                end else if (i_status.go_read) begin
                    n_state = ST_READ;
                end else begin
                    w_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            ST_READ: begin
                w_cmd.finish = 1'b1;
                w_cmd.rd_sel = 1'b1;
                n_state      = ST_IDLE;
            end
            ST_SWEEP: begin
                w_cmd.sweep_step = 1'b1;
                if (i_status.sweep_done) begin
                    w_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_cmd = w_cmd;
    assign busy  = (r_state != ST_IDLE);

    `TCW_ASSERT(a_exec_after_accept, i_clk, i_rst_n, (r_state == ST_EXEC) |-> $past(start && (r_state == ST_IDLE)), "exec without an accepted word")
    `TCW_ASSERT(a_finish_to_idle, i_clk, i_rst_n, w_cmd.finish |=> (r_state == ST_IDLE), "finish did not return to idle")
    `TCW_ASSERT_NR(a_busy_after_reset, i_clk, !i_rst_n |=> busy, "not busy during clearing pass")

endmodule

### src/tcw_dp.sv
// ----------------------------------------------------------------------------
// tcw_dp
// Datapath: cell store, cursor, scroll origin, sweep counter, result registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tcw_dp #(
    parameter int unsigned SCREEN_COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int unsigned SCREEN_ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  tcw_pkg::t_cfg                         i_cfg,
    input  tcw_pkg::t_dp_cmd                      i_cmd,
    output tcw_pkg::t_dp_status                   o_status,
    input  logic [tcw_pkg::OP_W-1:0]              i_operation,
    input  logic [tcw_pkg::CHAR_W-1:0]            i_character,
    input  logic [$clog2(SCREEN_COLUMNS)-1:0]     i_column,
    input  logic [$clog2(SCREEN_ROWS)-1:0]        i_row,
    output logic                                  o_done,
    output logic [tcw_pkg::CHAR_W-1:0]            o_cell_character,
    output logic [tcw_pkg::ATTR_W-1:0]            o_cell_attribute,
    output logic [$clog2(SCREEN_COLUMNS)-1:0]     o_cursor_column,
    output logic [$clog2(SCREEN_ROWS)-1:0]        o_cursor_row,
    output logic                                  o_scrolled
);
    import tcw_pkg::*;

    localparam int unsigned COL_W  = $clog2(SCREEN_COLUMNS);
    localparam int unsigned ROW_W  = $clog2(SCREEN_ROWS);
    localparam int unsigned CELLS  = SCREEN_COLUMNS * SCREEN_ROWS;
    localparam int unsigned ADDR_W = $clog2(CELLS);

    localparam logic [COL_W-1:0]  COL_MAX    = COL_W'(SCREEN_COLUMNS - 1);
    localparam logic [ROW_W-1:0]  ROW_MAX    = ROW_W'(SCREEN_ROWS - 1);
    localparam logic [ROW_W-1:0]  ROW_ONE    = ROW_W'(1);
    localparam logic [COL_W:0]    COLS_EXT   = (COL_W + 1)'(SCREEN_COLUMNS);
    localparam logic [ROW_W:0]    ROWS_EXT   = (ROW_W + 1)'(SCREEN_ROWS);
    localparam logic [COL_W:0]    TAB_EXT    = (COL_W + 1)'(TAB_STEP);
    localparam logic [ADDR_W-1:0] COLS_A     = ADDR_W'(SCREEN_COLUMNS);
    localparam logic [ADDR_W-1:0] COLS_LAST  = ADDR_W'(SCREEN_COLUMNS - 1);
    localparam logic [ADDR_W-1:0] CELLS_LAST = ADDR_W'(CELLS - 1);

    // (a + b) mod rows, both operands below rows
    function automatic logic [ROW_W-1:0] f_row_wrap(input logic [ROW_W-1:0] a,
                                                    input logic [ROW_W-1:0] b);
        logic [ROW_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= ROWS_EXT) s = s - ROWS_EXT;
        return s[ROW_W-1:0];
    endfunction

    logic [CELL_W-1:0] r_mem [CELLS];

    t_op               r_op;
    logic [CHAR_W-1:0] r_ch;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;

    // logical cursor, its physical row, and the physical row shown on top
    logic [COL_W-1:0]  r_cur_x,    n_cur_x;
    logic [ROW_W-1:0]  r_cur_y,    n_cur_y;
    logic [ROW_W-1:0]  r_cur_phys, n_cur_phys;
    logic [ROW_W-1:0]  r_top,      n_top;
    logic              r_scrolled, n_scrolled;
    logic [ADDR_W-1:0] r_sweep_addr, n_sweep_addr;
    logic [ADDR_W-1:0] r_sweep_last, n_sweep_last;

    logic [CELL_W-1:0] r_rdata;
    logic              r_done;
    logic [CHAR_W-1:0] r_out_char;
    logic [ATTR_W-1:0] r_out_attr;
    logic [COL_W-1:0]  r_out_col;
    logic [ROW_W-1:0]  r_out_row;
    logic              r_out_scr;

    logic              w_is_nl, w_is_bs, w_is_tab, w_is_text;
    logic              w_col_end, w_last_row, w_row_adv, w_scroll, w_rd_ok;
    logic [COL_W:0]    w_tab_sum;
    logic [COL_W-1:0]  w_set_x;
    logic [ROW_W-1:0]  w_set_y;
    logic [ROW_W-1:0]  w_rd_phys;
    logic [ADDR_W-1:0] w_rd_addr, w_cur_addr, w_top_base;
    logic              w_char_wr, w_mem_we;
    logic [ADDR_W-1:0] w_mem_waddr;
    logic [CELL_W-1:0] w_mem_wdata;

    // newline wins over backspace, backspace over tab
    assign w_is_nl   = (r_ch == i_cfg.newline_code);
    assign w_is_bs   = !w_is_nl && (r_ch == i_cfg.backspace_code);
    assign w_is_tab  = !w_is_nl && !w_is_bs && (r_ch == i_cfg.tab_code);
    assign w_is_text = !w_is_nl && !w_is_bs && !w_is_tab;

    assign w_col_end  = (r_cur_x == COL_MAX);
    assign w_last_row = (r_cur_y == ROW_MAX);
    assign w_row_adv  = (r_op == OP_PUT) && (w_is_nl || (w_is_text && w_col_end));
    assign w_scroll   = w_row_adv && w_last_row;
    assign w_rd_ok    = (r_op == OP_READ) && ({1'b0, r_col} < COLS_EXT)
                        && ({1'b0, r_row} < ROWS_EXT);
    assign w_tab_sum  = {1'b0, r_cur_x} + TAB_EXT;
    assign w_set_x    = (r_col > COL_MAX) ? COL_MAX : r_col;
    assign w_set_y    = (r_row > ROW_MAX) ? ROW_MAX : r_row;

    assign w_rd_phys  = f_row_wrap(r_row, r_top);
    assign w_rd_addr  = ADDR_W'(w_rd_phys) * COLS_A + ADDR_W'(r_col);
    assign w_cur_addr = ADDR_W'(r_cur_phys) * COLS_A + ADDR_W'(r_cur_x);
    assign w_top_base = ADDR_W'(r_top) * COLS_A;

    always_comb begin
        n_cur_x      = r_cur_x;
        n_cur_y      = r_cur_y;
        n_cur_phys   = r_cur_phys;
        n_top        = r_top;
        n_scrolled   = r_scrolled;
        n_sweep_addr = r_sweep_addr;
        n_sweep_last = r_sweep_last;
        if (i_cmd.exec) begin
            n_scrolled = 1'b0;
            unique case (r_op)
                OP_PUT: begin
                    priority if (w_row_adv) begin
                        n_cur_x = '0;
                        if (w_last_row) begin
                            // old top row becomes the blank bottom row
                            n_cur_phys   = r_top;
                            n_top        = f_row_wrap(r_top, ROW_ONE);
                            n_scrolled   = 1'b1;
                            n_sweep_addr = w_top_base;
                            n_sweep_last = w_top_base + COLS_LAST;
                        end else begin
                            n_cur_y    = r_cur_y + ROW_ONE;
                            n_cur_phys = f_row_wrap(r_cur_phys, ROW_ONE);
                        end
                    end else if (w_is_bs) begin
                        if (r_cur_x != '0) n_cur_x = r_cur_x - COL_W'(1);
                    end else if (w_is_tab) begin
                        if (w_tab_sum < COLS_EXT) n_cur_x = w_tab_sum[COL_W-1:0];
                    end else begin
                        n_cur_x = r_cur_x + COL_W'(1);
                    end
                end
                OP_SET: begin
                    n_cur_x    = w_set_x;
                    n_cur_y    = w_set_y;
                    n_cur_phys = f_row_wrap(w_set_y, r_top);
                end
                OP_CLEAR: begin
                    n_cur_x      = '0;
                    n_cur_y      = '0;
                    n_cur_phys   = '0;
                    n_top        = '0;
                    n_sweep_addr = '0;
                    n_sweep_last = CELLS_LAST;
                end
                OP_READ: begin
                end
            endcase
        end
        if (i_cmd.sweep_step) n_sweep_addr = r_sweep_addr + ADDR_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x      <= '0;
            r_cur_y      <= '0;
            r_cur_phys   <= '0;
            r_top        <= '0;
            r_scrolled   <= 1'b0;
            r_sweep_addr <= '0;
            r_sweep_last <= CELLS_LAST;
            r_done       <= 1'b0;
        end else begin
            r_cur_x      <= n_cur_x;
            r_cur_y      <= n_cur_y;
            r_cur_phys   <= n_cur_phys;
            r_top        <= n_top;
            r_scrolled   <= n_scrolled;
            r_sweep_addr <= n_sweep_addr;
            r_sweep_last <= n_sweep_last;
            r_done       <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= t_op'(i_operation);
            r_ch  <= i_character;
            r_col <= i_column;
            r_row <= i_row;
        end
        if (i_cmd.finish) begin
            r_out_char <= i_cmd.rd_sel ? r_rdata[CHAR_W-1:0] : '0;
            r_out_attr <= i_cmd.rd_sel ? r_rdata[CELL_W-1:CHAR_W] : '0;
            r_out_col  <= n_cur_x;
            r_out_row  <= n_cur_y;
            r_out_scr  <= n_scrolled;
        end
    end

    // cell store: one write port (text or sweep), one registered read port
    assign w_char_wr   = i_cmd.exec && (r_op == OP_PUT) && w_is_text;
    assign w_mem_we    = w_char_wr || i_cmd.sweep_step;
    assign w_mem_waddr = i_cmd.sweep_step ? r_sweep_addr : w_cur_addr;
    assign w_mem_wdata = i_cmd.sweep_step ? '0 : {i_cfg.text_attribute, r_ch};

    always_ff @(posedge i_clk) begin
        if (w_mem_we) r_mem[w_mem_waddr] <= w_mem_wdata;
        if (i_cmd.exec) r_rdata <= r_mem[w_rd_addr];
    end

    assign o_status.go_clear   = (r_op == OP_CLEAR);
    assign o_status.go_scroll  = w_scroll;
    assign o_status.go_read    = w_rd_ok;
    assign o_status.sweep_done = (r_sweep_addr == r_sweep_last);

    assign o_done           = r_done;
    assign o_cell_character = r_out_char;
    assign o_cell_attribute = r_out_attr;
    assign o_cursor_column  = r_out_col;
    assign o_cursor_row     = r_out_row;
    assign o_scrolled       = r_out_scr;

    `TCW_ASSERT(a_done_single, i_clk, i_rst_n, r_done |=> !r_done, "result strobe held two cycles")
    `TCW_ASSERT(a_cursor_range, i_clk, i_rst_n, (r_cur_x <= COL_MAX) && (r_cur_y <= ROW_MAX) && (r_top <= ROW_MAX) && (r_cur_phys <= ROW_MAX), "cursor or top row out of range")
    `TCW_ASSERT(a_sweep_bound, i_clk, i_rst_n, i_cmd.sweep_step |-> (r_sweep_addr <= r_sweep_last), "sweep ran past its last cell")

endmodule

### src/text_console_writer_unit.sv
// ----------------------------------------------------------------------------
// text_console_writer_unit
// Text console: character cell store with cursor, scroll, clear and readback.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; its result appears on
// the o_ ports for exactly one cycle with o_done high and cannot be held off.
// Steps from accept to the strobe: put without scroll, set cursor and
// out-of-range read pass an accept step and an execute step; a read of a
// valid cell adds a wait for the registered store read. A put that scrolls
// moves the row origin and zeroes one row of the store, one cell per cycle
// through its single write port. Clear screen zeroes the whole store the
// same way. After reset busy stays high while the store is zeroed; register
// writes are taken meanwhile. busy drops in the strobe cycle, so a new word
// may be taken alongside a result.
module text_console_writer_unit #(
    parameter int unsigned SCREEN_COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int unsigned SCREEN_ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [tcw_pkg::OP_W-1:0]              i_operation,
    input  logic [tcw_pkg::CHAR_W-1:0]            i_character,
    input  logic [$clog2(SCREEN_COLUMNS)-1:0]     i_column,
    input  logic [$clog2(SCREEN_ROWS)-1:0]        i_row,
    output logic                                  o_done,
    output logic [tcw_pkg::CHAR_W-1:0]            o_cell_character,
    output logic [tcw_pkg::ATTR_W-1:0]            o_cell_attribute,
    output logic [$clog2(SCREEN_COLUMNS)-1:0]     o_cursor_column,
    output logic [$clog2(SCREEN_ROWS)-1:0]        o_cursor_row,
    output logic                                  o_scrolled,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [tcw_pkg::APB_ADDR_W-1:0]        paddr,
    input  logic [tcw_pkg::APB_DATA_W-1:0]        pwdata,
    output logic [tcw_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                  pready
);
    import tcw_pkg::*;

    t_cfg       w_cfg;
    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    tcw_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    tcw_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    tcw_dp #(
        .SCREEN_COLUMNS (SCREEN_COLUMNS),
        .SCREEN_ROWS    (SCREEN_ROWS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (w_cfg),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_operation      (i_operation),
        .i_character      (i_character),
        .i_column         (i_column),
        .i_row            (i_row),
        .o_done           (o_done),
        .o_cell_character (o_cell_character),
        .o_cell_attribute (o_cell_attribute),
        .o_cursor_column  (o_cursor_column),
        .o_cursor_row     (o_cursor_row),
        .o_scrolled       (o_scrolled)
    );

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// Text console writer testbench
// Drives command words and APB register writes into the console. Each result
// word is checked against a cycle-free model of the cell store and cursor.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    localparam int unsigned COLS  = DEF_COLUMNS;
    localparam int unsigned ROWS  = DEF_ROWS;
    localparam int unsigned CELLS = COLS * ROWS;
    localparam int unsigned COL_W = $clog2(COLS);
    localparam int unsigned ROW_W = $clog2(ROWS);

    localparam int WORDS_PER_PHASE = 135;
    localparam int DRAIN_CYCLES    = CELLS + 100;   // longer than a full clear
    localparam int CYCLE_LIMIT     = 1_000_000;

    typedef enum int unsigned {
        REG_TEXT_ATTR = 0,
        REG_NEWLINE   = 1,
        REG_BACKSPACE = 2,
        REG_TAB       = 3
    } t_reg;

    typedef struct packed {
        logic [CHAR_W-1:0] cell_char;
        logic [ATTR_W-1:0] cell_attr;
        logic [COL_W-1:0]  cur_col;
        logic [ROW_W-1:0]  cur_row;
        logic              scrolled;
    } t_cursor_report;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [OP_W-1:0]       i_operation;
    logic [CHAR_W-1:0]     i_character;
    logic [COL_W-1:0]      i_column;
    logic [ROW_W-1:0]      i_row;
    logic                  o_done;
    logic [CHAR_W-1:0]     o_cell_character;
    logic [ATTR_W-1:0]     o_cell_attribute;
    logic [COL_W-1:0]      o_cursor_column;
    logic [ROW_W-1:0]      o_cursor_row;
    logic                  o_scrolled;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // console model state
    bit [CELL_W-1:0] screen [CELLS];
    bit [COL_W-1:0]  cur_col;
    bit [ROW_W-1:0]  cur_row;
    t_cfg            console_cfg;

    t_cursor_report  reports_due [$];
    t_cursor_report  report_head;

    int sender_idle_pct;
    int words_sent;
    int scroll_count;
    int clear_count;
    int read_count;
    int settings_count;
    int fail_count;
    int cycle_count;

    text_console_writer_unit u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_operation      (i_operation),
        .i_character      (i_character),
        .i_column         (i_column),
        .i_row            (i_row),
        .o_done           (o_done),
        .o_cell_character (o_cell_character),
        .o_cell_attribute (o_cell_attribute),
        .o_cursor_column  (o_cursor_column),
        .o_cursor_row     (o_cursor_row),
        .o_scrolled       (o_scrolled),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles, %0d words still due", cycle_count,
                     reports_due.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Console model
    // ------------------------------------------------------------------

    // cursor to the next row; scrolls when already on the last row
    function automatic logic line_feed();
        if (int'(cur_row) == ROWS - 1) begin
            for (int i = 0; i < CELLS - COLS; i++) screen[i] = screen[i + COLS];
            for (int i = CELLS - COLS; i < CELLS; i++) screen[i] = '0;
            return 1'b1;
        end
        cur_row++;
        return 1'b0;
    endfunction

    function automatic t_cursor_report advance_console(input t_op op,
            input logic [CHAR_W-1:0] ch, input logic [COL_W-1:0] col,
            input logic [ROW_W-1:0] row);
        t_cursor_report rep;
        logic [CELL_W-1:0] stored;
        rep = '0;
        case (op)
            OP_PUT: begin
                // newline beats backspace beats tab when codes coincide
                if (ch == console_cfg.newline_code) begin
                    cur_col = '0;
                    rep.scrolled = line_feed();
                end else if (ch == console_cfg.backspace_code) begin
                    if (cur_col != 0) cur_col--;
                end else if (ch == console_cfg.tab_code) begin
                    if (int'(cur_col) + TAB_STEP < COLS) cur_col = cur_col + COL_W'(TAB_STEP);
                end else begin
                    screen[int'(cur_row) * COLS + int'(cur_col)] =
                        {console_cfg.text_attribute, ch};
                    if (int'(cur_col) == COLS - 1) begin
                        cur_col = '0;
                        rep.scrolled = line_feed();
                    end else begin
                        cur_col++;
                    end
                end
            end
            OP_SET: begin
                cur_col = (col > COLS - 1) ? COL_W'(COLS - 1) : col;
                cur_row = (row > ROWS - 1) ? ROW_W'(ROWS - 1) : row;
            end
            OP_CLEAR: begin
                foreach (screen[i]) screen[i] = '0;
                cur_col = '0;
                cur_row = '0;
                clear_count++;
            end
            default: begin
                read_count++;
                if (col < COLS && row < ROWS) begin
                    stored = screen[int'(row) * COLS + int'(col)];
                    rep.cell_char = stored[CHAR_W-1:0];
                    rep.cell_attr = stored[CELL_W-1:CHAR_W];
                end
            end
        endcase
        rep.cur_col = cur_col;
        rep.cur_row = cur_row;
        if (rep.scrolled) scroll_count++;
        return rep;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1) begin
            if (reports_due.size() == 0) begin
                $error("result word with no word outstanding");
                fail_count++;
            end else begin
                report_head = reports_due.pop_front();
                if (o_cell_character !== report_head.cell_char) begin
                    $error("cell_character: expected %0d, got %0d",
                           report_head.cell_char, o_cell_character);
                    fail_count++;
                end
                if (o_cell_attribute !== report_head.cell_attr) begin
                    $error("cell_attribute: expected %0d, got %0d",
                           report_head.cell_attr, o_cell_attribute);
                    fail_count++;
                end
                if (o_cursor_column !== report_head.cur_col) begin
                    $error("cursor_column: expected %0d, got %0d",
                           report_head.cur_col, o_cursor_column);
                    fail_count++;
                end
                if (o_cursor_row !== report_head.cur_row) begin
                    $error("cursor_row: expected %0d, got %0d",
                           report_head.cur_row, o_cursor_row);
                    fail_count++;
                end
                if (o_scrolled !== report_head.scrolled) begin
                    $error("scrolled: expected %0d, got %0d",
                           report_head.scrolled, o_scrolled);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Drivers; every task is entered and left just after a falling edge
    // ------------------------------------------------------------------
    task automatic send_word(input t_op op, input logic [CHAR_W-1:0] ch,
            input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row);
        int gap;
        start       <= 1'b1;
        i_operation <= op;
        i_character <= ch;
        i_column    <= col;
        i_row       <= row;
        do @(posedge i_clk); while (busy !== 1'b0);
        reports_due.push_back(advance_console(op, ch, col, row));
        words_sent++;
        @(negedge i_clk);
        // start stays high into the next word unless the sender idles
        if ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            gap = $urandom_range(1, 12);
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic put_char(input logic [CHAR_W-1:0] ch);
        send_word(OP_PUT, ch, '0, '0);
    endtask

    task automatic set_cursor(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row);
        send_word(OP_SET, '0, col, row);
    endtask

    task automatic read_cell(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row);
        send_word(OP_READ, '0, col, row);
    endtask

    // all four registers, written once every word in flight has come back
    task automatic apply_settings(input t_cfg cfg);
        start <= 1'b0;
        while (reports_due.size() != 0) @(negedge i_clk);
        for (int r = REG_TEXT_ATTR; r <= REG_TAB; r++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= APB_ADDR_W'(4 * r);
            pwdata  <= {24'($urandom), cfg[8 * (3 - r) +: 8]};
            @(negedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (pready !== 1'b1);
            @(negedge i_clk);
            psel    <= 1'b0;
            penable <= 1'b0;
            @(negedge i_clk);
        end
        console_cfg = cfg;
        settings_count++;
    endtask

    task automatic random_word();
        int pick;
        int run;
        logic [CHAR_W-1:0] ch;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        // unused fields carry noise
        col  = COL_W'($urandom_range(0, 127));
        row  = ROW_W'($urandom_range(0, 31));
        pick = $urandom_range(99);
        if (pick < 2) begin
            send_word(OP_CLEAR, CHAR_W'($urandom_range(0, 255)), col, row);
        end else if (pick < 14) begin
            if ($urandom_range(99) < 85) col = COL_W'($urandom_range(0, COLS - 1));
            if ($urandom_range(99) < 80)
                row = ($urandom_range(99) < 40) ? ROW_W'(ROWS - 1)
                                                : ROW_W'($urandom_range(0, ROWS - 1));
            send_word(OP_SET, CHAR_W'($urandom_range(0, 255)), col, row);
        end else if (pick < 40) begin
            if ($urandom_range(99) < 90) col = COL_W'($urandom_range(0, COLS - 1));
            if ($urandom_range(99) < 90)
                row = $urandom_range(1) ? cur_row : ROW_W'($urandom_range(0, ROWS - 1));
            send_word(OP_READ, CHAR_W'($urandom_range(0, 255)), col, row);
        end else if (pick < 55) begin
            // a run of printable text
            run = $urandom_range(2, 16);
            repeat (run) send_word(OP_PUT, CHAR_W'($urandom_range(8'h20, 8'h7e)), col, row);
        end else begin
            case ($urandom_range(3))
                0:       ch = console_cfg.newline_code;
                1:       ch = console_cfg.backspace_code;
                2:       ch = console_cfg.tab_code;
                default: ch = CHAR_W'($urandom_range(0, 255));
            endcase
            send_word(OP_PUT, ch, col, row);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_put_and_cursor();
        apply_settings({8'ha5, RST_NEWLINE, RST_BACKSPACE, RST_TAB});
        read_cell(0, 0);
        put_char(8'h41);
        put_char(8'h00);
        put_char(8'hff);
        put_char(RST_BACKSPACE);
        read_cell(2, 0);                 // backspace leaves the cell alone
        set_cursor(0, 0);
        put_char(RST_BACKSPACE);         // already at column zero
        put_char(RST_TAB);
        set_cursor(75, 3);
        put_char(RST_TAB);               // lands on the last column
        put_char(RST_TAB);               // would leave the row
        set_cursor(76, 3);
        put_char(RST_TAB);
        set_cursor(79, 3);
        put_char(8'h7a);                 // wraps to the next row
        put_char(RST_NEWLINE);
    endtask

    task automatic test_scroll_and_clear();
        set_cursor(127, 31);             // saturates to the bottom right corner
        put_char(8'h71);                 // wrap off the last row scrolls
        read_cell(79, 23);
        read_cell(79, 2);
        read_cell(2, 0);
        put_char(RST_NEWLINE);           // newline on the last row scrolls
        read_cell(79, 22);
        read_cell(80, 0);
        read_cell(0, 25);
        read_cell(127, 31);
        send_word(OP_CLEAR, 8'h55, 7'h2a, 5'h15);
        read_cell(79, 21);
        set_cursor(79, 24);
        read_cell(79, 24);
    endtask

    task automatic test_code_priority();
        apply_settings({8'hff, 8'h2a, 8'h2a, 8'h2a});
        set_cursor(5, 5);
        put_char(8'h2a);                 // newline wins
        apply_settings({8'hff, 8'h11, 8'h2a, 8'h2a});
        set_cursor(5, 5);
        put_char(8'h2a);                 // backspace wins over tab
        apply_settings({8'hff, 8'h11, 8'h30, 8'h2a});
        put_char(8'h2a);
        put_char(RST_NEWLINE);           // now an ordinary character
        read_cell(8, 5);
    endtask

    task automatic test_random_traffic();
        t_cfg cfg;
        int idle_pct [5];
        int target;
        idle_pct = '{0, 77, 6, 77, 0};
        for (int p = 0; p < 5; p++) begin
            cfg = {8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
            case (p)
                0:       cfg = {8'hff, 8'h00, 8'hff, 8'h80};
                1:       cfg = {8'h00, 8'hff, 8'h00, 8'h7f};
                2:       cfg = {cfg.text_attribute, RST_NEWLINE, RST_BACKSPACE, RST_TAB};
                4:       cfg = {cfg.text_attribute, 8'h0d, 8'h7f, RST_TAB};
                default: ;
            endcase
            apply_settings(cfg);
            sender_idle_pct = idle_pct[p];
            target = words_sent + WORDS_PER_PHASE;
            while (words_sent < target) random_word();
        end
    endtask

    initial begin
        start       = 1'b0;
        i_operation = OP_PUT;
        i_character = '0;
        i_column    = '0;
        i_row       = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        i_rst_n     = 1'b0;
        console_cfg = {RST_ATTR, RST_NEWLINE, RST_BACKSPACE, RST_TAB};
        sender_idle_pct = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_put_and_cursor();
        test_scroll_and_clear();
        test_code_priority();
        test_random_traffic();

        start <= 1'b0;
        while (reports_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d words under %0d register settings with mixed sender gaps",
                 words_sent, settings_count);
        $display("Model saw %0d scrolls, %0d clears and %0d cell reads; %0d mismatches",
                 scroll_count, clear_count, read_count, fail_count);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
